// ===== src/nec_ir_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nec_ir_pkg
// Types and timing windows shared by the pulse-distance remote decoder.
// ----------------------------------------------------------------------------
package nec_ir_pkg;

   // widths of the stream words
   localparam int unsigned EDGE_TIME_WIDTH = 32;
   localparam int unsigned BYTE_WIDTH      = 8;
   localparam int unsigned FRAME_WIDTH     = 32;
   localparam int unsigned BIT_COUNT_WIDTH = 6;
   localparam int unsigned REQ_DATA_WIDTH  = 32;
   localparam int unsigned RSP_DATA_WIDTH  = 16;

   // bits in a complete frame
   localparam logic [BIT_COUNT_WIDTH-1:0] FRAME_BITS_FULL = 6'd32;

   // interval windows in microseconds
   localparam logic [EDGE_TIME_WIDTH-1:0] GLITCH_MAX_US      = 32'd800;
   localparam logic [EDGE_TIME_WIDTH-1:0] PREAMBLE_MIN_US    = 32'd13400;
   localparam logic [EDGE_TIME_WIDTH-1:0] PREAMBLE_MAX_US    = 32'd13700;
   localparam logic [EDGE_TIME_WIDTH-1:0] ZERO_LOW_US        = 32'd1000;
   localparam logic [EDGE_TIME_WIDTH-1:0] ZERO_HIGH_US       = 32'd1500;
   localparam logic [EDGE_TIME_WIDTH-1:0] ONE_LOW_US         = 32'd2000;
   localparam logic [EDGE_TIME_WIDTH-1:0] ONE_HIGH_US        = 32'd2500;
   localparam logic [EDGE_TIME_WIDTH-1:0] LOCK1_MIN_US       = 32'd39500;
   localparam logic [EDGE_TIME_WIDTH-1:0] LOCK1_MAX_US       = 32'd41000;
   localparam logic [EDGE_TIME_WIDTH-1:0] REPEAT_MIN_US      = 32'd11000;
   localparam logic [EDGE_TIME_WIDTH-1:0] REPEAT_MAX_US      = 32'd11500;
   localparam logic [EDGE_TIME_WIDTH-1:0] LOCK2_MIN_US       = 32'd96000;
   localparam logic [EDGE_TIME_WIDTH-1:0] LOCK2_MAX_US       = 32'd98000;

   // decoder phase
   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_DATA   = 3'd1,
      PH_REPEAT = 3'd2,
      PH_LOCK1  = 3'd3,
      PH_LOCK2  = 3'd4
   } phase_type;

   // all decoder state carried between words
   typedef struct packed {
      phase_type                    phase;
      logic [EDGE_TIME_WIDTH-1:0]   prior_edge_time;
      logic [FRAME_WIDTH-1:0]       frame_bits;
      logic [BIT_COUNT_WIDTH-1:0]   bits_received;
      logic [BYTE_WIDTH-1:0]        held_address;
      logic [BYTE_WIDTH-1:0]        held_command;
   } decoder_state_type;

   // one decoded button word
   typedef struct packed {
      logic                   valid;
      logic [BYTE_WIDTH-1:0]  button_address;
      logic [BYTE_WIDTH-1:0]  button_command;
      logic                   is_repeat;
   } button_result_type;

endpackage : nec_ir_pkg
`default_nettype wire

// ===== src/nec_ir_step.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nec_ir_step
// Next-state and result logic for one edge timestamp: interval, phase
// transition, bit shift and frame check.
// ----------------------------------------------------------------------------
module nec_ir_step (
   input  wire nec_ir_pkg::decoder_state_type                  state_cur,
   input  wire logic [nec_ir_pkg::EDGE_TIME_WIDTH-1:0]         edge_time,
   output nec_ir_pkg::decoder_state_type                       state_nxt,
   output nec_ir_pkg::button_result_type                       result
);

   logic [nec_ir_pkg::EDGE_TIME_WIDTH-1:0] delta;
   logic                                   bit_is_one;
   logic [nec_ir_pkg::FRAME_WIDTH-1:0]     frame_shifted;
   logic [nec_ir_pkg::BYTE_WIDTH-1:0]      addr_byte;
   logic [nec_ir_pkg::BYTE_WIDTH-1:0]      addr_inv_byte;
   logic [nec_ir_pkg::BYTE_WIDTH-1:0]      cmd_byte;
   logic [nec_ir_pkg::BYTE_WIDTH-1:0]      cmd_inv_byte;
   logic                                   frame_good;

   // elapsed time, wraps modulo 2^32
   assign delta = edge_time - state_cur.prior_edge_time;

   // frame as it stands after this edge's shift
   assign bit_is_one    = (delta > nec_ir_pkg::ONE_LOW_US) && (delta < nec_ir_pkg::ONE_HIGH_US);
   assign frame_shifted = {state_cur.frame_bits[30:0], bit_is_one};

   // byte split of the frame after this edge's shift
   assign addr_byte     = frame_shifted[31:24];
   assign addr_inv_byte = frame_shifted[23:16];
   assign cmd_byte      = frame_shifted[15:8];
   assign cmd_inv_byte  = frame_shifted[7:0];
   assign frame_good    = (addr_byte == ~addr_inv_byte) && (cmd_byte == ~cmd_inv_byte);

   // phase machine for one edge
   always_comb begin
      state_nxt             = state_cur;
      result.valid          = 1'b0;
      result.button_address = state_cur.held_address;
      result.button_command = state_cur.held_command;
      result.is_repeat      = 1'b1;

      if (delta >= nec_ir_pkg::GLITCH_MAX_US) begin
         case (state_cur.phase)
            nec_ir_pkg::PH_IDLE: begin
               state_nxt.frame_bits      = '0;
               state_nxt.bits_received   = '0;
               state_nxt.prior_edge_time = edge_time;
               if (delta >= nec_ir_pkg::PREAMBLE_MIN_US &&
                   delta <= nec_ir_pkg::PREAMBLE_MAX_US) begin
                  state_nxt.phase = nec_ir_pkg::PH_DATA;
               end
            end
            nec_ir_pkg::PH_DATA: begin
               state_nxt.prior_edge_time = edge_time;
               // msb-first shift of a zero or one symbol
               if (delta > nec_ir_pkg::ZERO_LOW_US && delta < nec_ir_pkg::ZERO_HIGH_US) begin
                  state_nxt.frame_bits    = {state_cur.frame_bits[30:0], 1'b0};
                  state_nxt.bits_received = state_cur.bits_received + 6'd1;
               end else if (delta > nec_ir_pkg::ONE_LOW_US &&
                            delta < nec_ir_pkg::ONE_HIGH_US) begin
                  state_nxt.frame_bits    = {state_cur.frame_bits[30:0], 1'b1};
                  state_nxt.bits_received = state_cur.bits_received + 6'd1;
               end else begin
                  state_nxt.phase         = nec_ir_pkg::PH_IDLE;
                  state_nxt.bits_received = '0;
               end
               // full frame: check inverted copies
               if (state_nxt.bits_received == nec_ir_pkg::FRAME_BITS_FULL) begin
                  if (frame_good) begin
                     state_nxt.held_address = addr_byte;
                     state_nxt.held_command = cmd_byte;
                     state_nxt.phase        = nec_ir_pkg::PH_LOCK1;
                     result.valid           = 1'b1;
                     result.button_address  = addr_byte;
                     result.button_command  = cmd_byte;
                     result.is_repeat       = 1'b0;
                  end else begin
                     state_nxt.phase = nec_ir_pkg::PH_IDLE;
                  end
               end
            end
            nec_ir_pkg::PH_LOCK1: begin
               if (delta > nec_ir_pkg::LOCK1_MAX_US) begin
                  state_nxt.phase           = nec_ir_pkg::PH_IDLE;
                  state_nxt.prior_edge_time = edge_time;
               end else if (delta >= nec_ir_pkg::LOCK1_MIN_US) begin
                  state_nxt.phase           = nec_ir_pkg::PH_REPEAT;
                  state_nxt.prior_edge_time = edge_time;
               end
            end
            nec_ir_pkg::PH_REPEAT: begin
               if (delta > nec_ir_pkg::REPEAT_MAX_US) begin
                  state_nxt.phase           = nec_ir_pkg::PH_IDLE;
                  state_nxt.prior_edge_time = edge_time;
               end else if (delta >= nec_ir_pkg::REPEAT_MIN_US) begin
                  state_nxt.phase           = nec_ir_pkg::PH_LOCK2;
                  state_nxt.prior_edge_time = edge_time;
                  result.valid              = 1'b1;
               end
            end
            nec_ir_pkg::PH_LOCK2: begin
               if (delta > nec_ir_pkg::LOCK2_MAX_US) begin
                  state_nxt.phase           = nec_ir_pkg::PH_IDLE;
                  state_nxt.prior_edge_time = edge_time;
               end else if (delta >= nec_ir_pkg::LOCK2_MIN_US) begin
                  state_nxt.phase           = nec_ir_pkg::PH_REPEAT;
                  state_nxt.prior_edge_time = edge_time;
               end
            end
            default: begin
               state_nxt.phase           = nec_ir_pkg::PH_IDLE;
               state_nxt.prior_edge_time = edge_time;
            end
         endcase
      end
   end

endmodule : nec_ir_step
`default_nettype wire

// ===== src/nec_ir_pulse_distance_decoder_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nec_ir_pulse_distance_decoder_unit
// Pulse-distance infrared remote decoder working on falling-edge timestamps.
// ----------------------------------------------------------------------------
// Each request word is the free-running microsecond timestamp of one falling
// edge of the receiver output. The unit measures the interval since the last
// accepted edge, finds the preamble, shifts in 32 data bits msb first, checks
// the address and command against their inverted copies and sends one
// response word per good frame, then one more for each correctly timed repeat
// frame (is_repeat set). Edges that arrive too soon are dropped and give no
// response. The unit takes one word per clock while the response side does
// not stall: a word is held in the input register, then the interval
// subtract and window compares run in one pass into the decoder state and
// response register. Back-pressure on the response side stalls the input
// register only while a response waits unread.
// ----------------------------------------------------------------------------
module nec_ir_pulse_distance_decoder_unit (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   // request stream
   input  wire logic                                      req_tvalid,
   output logic                                           req_tready,
   input  wire logic [nec_ir_pkg::REQ_DATA_WIDTH-1:0]     req_tdata,  // [31:0] edge_time
   // response stream
   output logic                                           rsp_tvalid,
   input  wire logic                                      rsp_tready,
   output logic [nec_ir_pkg::RSP_DATA_WIDTH-1:0]          rsp_tdata,  // [7:0] button_address,
                                                                      // [15:8] button_command
   output logic                                           rsp_tuser   // [0] is_repeat
);

   logic                                        in_valid_ff;
   logic [nec_ir_pkg::EDGE_TIME_WIDTH-1:0]      in_time_ff;
   logic [nec_ir_pkg::EDGE_TIME_WIDTH-1:0]      in_time_in;
   nec_ir_pkg::decoder_state_type               state_ff;
   nec_ir_pkg::decoder_state_type               state_in;
   nec_ir_pkg::button_result_type               step_result;
   logic                                        rsp_valid_ff;
   logic                                        rsp_valid_in;
   logic [nec_ir_pkg::RSP_DATA_WIDTH-1:0]       rsp_data_ff;
   logic [nec_ir_pkg::RSP_DATA_WIDTH-1:0]       rsp_data_in;
   logic                                        rsp_user_ff;
   logic                                        rsp_user_in;
   logic                                        step_fire;
   logic                                        in_valid_in;

   // decode step may run when the response slot is free or being emptied
   assign step_fire  = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step_fire;

   // input register
   always_comb begin
      in_valid_in = in_valid_ff;
      in_time_in  = in_time_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
         in_time_in  = req_tdata;
      end
   end

   // one-pass decode of the registered edge
   nec_ir_step u_step (
      .state_cur (state_ff),
      .edge_time (in_time_ff),
      .state_nxt (state_in),
      .result    (step_result)
   );

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (step_fire && step_result.valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {step_result.button_command, step_result.button_address};
         rsp_user_in  = step_result.is_repeat;
      end
   end

   // control and decoder state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff              <= 1'b0;
         rsp_valid_ff             <= 1'b0;
         state_ff.phase           <= nec_ir_pkg::PH_IDLE;
         state_ff.prior_edge_time <= '0;
         state_ff.frame_bits      <= '0;
         state_ff.bits_received   <= '0;
         state_ff.held_address    <= '0;
         state_ff.held_command    <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (step_fire) begin
            state_ff <= state_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      in_time_ff  <= in_time_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule : nec_ir_pulse_distance_decoder_unit
`default_nettype wire
